// ===== sv/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes for the double-ended queue: command and result
// payloads, command and status codes, and the classified queue entry.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DATA_W        = 32;
  localparam int DEPTH_DEFAULT = 64;

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_DUMP       = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]               cmd;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value_res;
    logic [1:0]               status;
    logic                     last;
  } res_t;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_DUMP
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic signed [DATA_W-1:0] value;
  } qent_t;

endpackage

// ===== sv/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed 32-bit values in a ring store.
//
// Commands arrive on the cmd channel (cmd_valid / cmd_stall / cmd_data):
// push front, push back, pop front, pop back and dump. Results leave on the
// res channel (res_valid / res_stall / res_data), one transfer per push or
// pop, one per stored value for a dump with last set on the final transfer.
// A pop or dump of an empty queue gives one empty status; a push on a full
// queue is dropped and reports full. Unused command codes give no result.
// A two-entry command queue separates intake from execution.
// A push result passes the command queue and the execution unit into the
// result register; a pop or dump also waits for a registered store read.
// A dump then gives one value per cycle while res_stall is low.
// Reset clears the queue to empty and drops any pending command or result.
// While a result is valid and res_stall is high, the result register holds
// and execution waits; intake takes commands until its queue holds two.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  deq_pkg::cmd_t cmd_data,
  output logic          res_valid,
  input  logic          res_stall,
  output deq_pkg::res_t res_data
);

  logic           q_valid;
  deq_pkg::qent_t q_data;
  logic           q_pop;

  deq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_data  (cmd_data),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop)
  );

  deq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

endmodule

// ===== sv/deq_ram.sv =====
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/deq_front.sv =====
// ----------------------------------------------------------------------------
// deq_front
// Command intake: accepts commands, decodes them into operations, drops
// unused codes and holds decoded entries in a two-entry queue.
// ----------------------------------------------------------------------------
module deq_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  deq_pkg::cmd_t  cmd_data,
  output logic           q_valid,
  output deq_pkg::qent_t q_data,
  input  logic           q_pop
);

  deq_pkg::qent_t slot [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;
  logic           take;
  logic           push;
  logic           code_ok;
  deq_pkg::op_t   op_dec;

  always_comb begin
    code_ok = 1'b1;
    op_dec  = deq_pkg::OP_DUMP;
    case (cmd_data.cmd)
      deq_pkg::CMD_PUSH_FRONT: op_dec = deq_pkg::OP_PUSH_FRONT;
      deq_pkg::CMD_PUSH_BACK:  op_dec = deq_pkg::OP_PUSH_BACK;
      deq_pkg::CMD_POP_FRONT:  op_dec = deq_pkg::OP_POP_FRONT;
      deq_pkg::CMD_POP_BACK:   op_dec = deq_pkg::OP_POP_BACK;
      deq_pkg::CMD_DUMP:       op_dec = deq_pkg::OP_DUMP;
      default:                 code_ok = 1'b0;
    endcase
  end

  assign cmd_stall = fill[1];
  assign take      = cmd_valid && !cmd_stall;
  assign push      = take && code_ok;
  assign q_valid   = fill != 2'd0;
  assign q_data    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{op: op_dec, value: cmd_data.value};
    end
  end

endmodule

// ===== sv/deq_back.sv =====
// ----------------------------------------------------------------------------
// deq_back
// Command execution: owns the ring pointers and element store, performs
// pushes, pops and dumps, and holds results in an output register.
// ----------------------------------------------------------------------------
module deq_back #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  deq_pkg::qent_t q_data,
  output logic           q_pop,
  output logic           res_valid,
  input  logic           res_stall,
  output deq_pkg::res_t  res_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] ONE_C    = CW'(1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t        state, state_next;
  logic [AW-1:0] front_idx, front_idx_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] rd_ptr, rd_ptr_next;
  logic [CW-1:0] rd_left, rd_left_next;
  logic          res_valid_next;
  deq_pkg::res_t res_data_next;

  logic                      we;
  logic [AW-1:0]             waddr;
  logic [deq_pkg::DATA_W-1:0] wdata;
  logic                      re;
  logic [AW-1:0]             raddr;
  logic [deq_pkg::DATA_W-1:0] rdata;

  logic          res_free;
  logic          is_full;
  logic          is_empty;
  logic [CW-1:0] count_m1;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] p);
    return (p == '0) ? LAST_IDX : p - AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[AW-1:0];
  endfunction

  deq_ram #(
    .WIDTH (deq_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign res_free = !res_valid || !res_stall;
  assign is_full  = count == DEPTH_C;
  assign is_empty = count == '0;
  assign count_m1 = count - ONE_C;

  always_comb begin
    state_next     = state;
    front_idx_next = front_idx;
    count_next     = count;
    rd_ptr_next    = rd_ptr;
    rd_left_next   = rd_left;
    res_valid_next = res_valid && res_stall;
    res_data_next  = res_data;
    q_pop          = 1'b0;
    we             = 1'b0;
    waddr          = front_idx;
    wdata          = q_data.value;
    re             = 1'b0;
    raddr          = front_idx;
    case (state)
      S_IDLE: begin
        if (q_valid && res_free) begin
          q_pop          = 1'b1;
          res_data_next  = '{value_res: '0, status: deq_pkg::ST_OK, last: 1'b1};
          case (q_data.op)
            deq_pkg::OP_PUSH_FRONT: begin
              res_valid_next = 1'b1;
              if (is_full) begin
                res_data_next.status = deq_pkg::ST_FULL;
              end else begin
                we             = 1'b1;
                waddr          = ring_dec(front_idx);
                front_idx_next = ring_dec(front_idx);
                count_next     = count + ONE_C;
              end
            end
            deq_pkg::OP_PUSH_BACK: begin
              res_valid_next = 1'b1;
              if (is_full) begin
                res_data_next.status = deq_pkg::ST_FULL;
              end else begin
                we         = 1'b1;
                waddr      = ring_add(front_idx, count[AW-1:0]);
                count_next = count + ONE_C;
              end
            end
            deq_pkg::OP_POP_FRONT: begin
              if (is_empty) begin
                res_valid_next       = 1'b1;
                res_data_next.status = deq_pkg::ST_EMPTY;
              end else begin
                re             = 1'b1;
                raddr          = front_idx;
                front_idx_next = ring_inc(front_idx);
                count_next     = count_m1;
                rd_left_next   = ONE_C;
                state_next     = S_READ;
              end
            end
            deq_pkg::OP_POP_BACK: begin
              if (is_empty) begin
                res_valid_next       = 1'b1;
                res_data_next.status = deq_pkg::ST_EMPTY;
              end else begin
                re           = 1'b1;
                raddr        = ring_add(front_idx, count_m1[AW-1:0]);
                count_next   = count_m1;
                rd_left_next = ONE_C;
                state_next   = S_READ;
              end
            end
            deq_pkg::OP_DUMP: begin
              if (is_empty) begin
                res_valid_next       = 1'b1;
                res_data_next.status = deq_pkg::ST_EMPTY;
              end else begin
                re           = 1'b1;
                raddr        = front_idx;
                rd_ptr_next  = ring_inc(front_idx);
                rd_left_next = count;
                state_next   = S_READ;
              end
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        if (res_free) begin
          res_valid_next = 1'b1;
          res_data_next  = '{value_res: rdata, status: deq_pkg::ST_OK,
                             last: rd_left == ONE_C};
          if (rd_left == ONE_C) begin
            state_next = S_IDLE;
          end else begin
            re           = 1'b1;
            raddr        = rd_ptr;
            rd_ptr_next  = ring_inc(rd_ptr);
            rd_left_next = rd_left - ONE_C;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front_idx <= '0;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      front_idx <= front_idx_next;
      count     <= count_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr   <= rd_ptr_next;
    rd_left  <= rd_left_next;
    res_data <= res_data_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("element count above depth");

  a_front_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, front_idx} < DEPTH_W)
    else $error("front index outside ring");

  a_read_left: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> rd_left != '0)
    else $error("read phase with nothing left to emit");

  a_full_push_keeps: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && q_pop && is_full &&
     (q_data.op == deq_pkg::OP_PUSH_FRONT || q_data.op == deq_pkg::OP_PUSH_BACK))
    |=> count == $past(count))
    else $error("dropped push changed element count");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && res_data == $past(res_data))
    else $error("stalled result lost or changed");

endmodule
